// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ptom_pkg.sv =====
// ----------------------------------------------------------------------------
// ptom_pkg
// shared constants and types for the price-time order matcher
// ----------------------------------------------------------------------------
package ptom_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

    localparam logic KIND_TRADE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_TRADE,
        ST_PLACE,
        ST_SUMMARY
    } state_t;

endpackage

// ===== rtl/core/price_time_order_matcher_top.sv =====
// a zero-quantity order goes straight to its summary word; otherwise trades repeat until the
// order fills or the book depth is reached, then any remainder rests; busy blocks new orders meanwhile
// the best-order search walks the opposite side one slot per cycle on one shared compare
// each trade or summary word is on the outputs for one cycle with out_valid high, no stall
// reset (rst_n low, async) empties both sides of the book and sets the next id to one
// ----------------------------------------------------------------------------
// price_time_order_matcher_top
// limit order book with price-time priority and a serial best-order search
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module price_time_order_matcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        is_buy,
    input  logic [15:0] limit_price,
    input  logic [15:0] quantity,
    output logic        out_valid,
    output logic        kind,
    output logic [15:0] fill_qty,
    output logic [15:0] fill_price,
    output logic [31:0] buy_order_id,
    output logic [31:0] sell_order_id,
    output logic [31:0] new_order_id,
    output logic        rejected,
    output logic        last
);

    ptom_pkg::state_t state_reg, state_next;

    logic [15:0] bid_price_reg [ptom_pkg::BOOK_DEPTH];
    logic [15:0] bid_qty_reg   [ptom_pkg::BOOK_DEPTH];
    logic [31:0] bid_id_reg    [ptom_pkg::BOOK_DEPTH];
    logic [15:0] ask_price_reg [ptom_pkg::BOOK_DEPTH];
    logic [15:0] ask_qty_reg   [ptom_pkg::BOOK_DEPTH];
    logic [31:0] ask_id_reg    [ptom_pkg::BOOK_DEPTH];

    logic [31:0] next_id_reg;
    logic [31:0] nid_reg;
    logic        buy_reg;
    logic [15:0] lim_reg;
    logic [15:0] rem_reg;
    logic        rej_reg;
    logic [ptom_pkg::IDX_W-1:0] idx_reg;
    logic [ptom_pkg::CNT_W-1:0] n_reg;

    logic        best_valid_reg;
    logic [ptom_pkg::IDX_W-1:0] best_idx_reg;
    logic [15:0] best_price_reg;
    logic [15:0] best_qty_reg;
    logic [31:0] best_id_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [15:0] fill_qty_reg;
    logic [15:0] fill_price_reg;
    logic [31:0] buy_id_reg;
    logic [31:0] sell_id_reg;
    logic [31:0] new_id_reg;
    logic        rejected_reg;
    logic        last_reg;

    localparam logic [ptom_pkg::IDX_W-1:0] IDX_LAST = ptom_pkg::IDX_W'(ptom_pkg::BOOK_DEPTH - 1);
    localparam logic [ptom_pkg::CNT_W-1:0] CNT_MAX  = ptom_pkg::CNT_W'(ptom_pkg::BOOK_DEPTH);

    // opposite side entry under the scan pointer
    logic [15:0] scan_price;
    logic [15:0] scan_qty;
    logic [31:0] scan_id;
    logic        scan_better;
    logic        crosses;
    logic [15:0] trade_qty;
    logic [15:0] rem_after;
    logic        free_found;
    logic [ptom_pkg::IDX_W-1:0] free_idx;

    assign scan_price = buy_reg ? ask_price_reg[idx_reg] : bid_price_reg[idx_reg];
    assign scan_qty   = buy_reg ? ask_qty_reg[idx_reg]   : bid_qty_reg[idx_reg];
    assign scan_id    = buy_reg ? ask_id_reg[idx_reg]    : bid_id_reg[idx_reg];

    always_comb
    begin
        if (!best_valid_reg)
            scan_better = 1'b1;
        else if (scan_price == best_price_reg)
            scan_better = scan_id < best_id_reg;
        else if (buy_reg)
            scan_better = scan_price < best_price_reg;
        else
            scan_better = scan_price > best_price_reg;
    end

    assign crosses   = buy_reg ? (best_price_reg <= lim_reg) : (best_price_reg >= lim_reg);
    assign trade_qty = (rem_reg < best_qty_reg) ? rem_reg : best_qty_reg;
    assign rem_after = rem_reg - trade_qty;

    // lowest empty slot on the order's own side
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ptom_pkg::BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if ((buy_reg ? bid_qty_reg[i] : ask_qty_reg[i]) == 16'd0)
            begin
                free_found = 1'b1;
                free_idx   = ptom_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptom_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = (quantity == 16'd0) ? ptom_pkg::ST_SUMMARY : ptom_pkg::ST_SCAN;
            end
            ptom_pkg::ST_SCAN:
            begin
                if (idx_reg == IDX_LAST)
                    state_next = ptom_pkg::ST_DECIDE;
            end
            ptom_pkg::ST_DECIDE:
            begin
                state_next = (best_valid_reg && crosses) ? ptom_pkg::ST_TRADE
                                                         : ptom_pkg::ST_PLACE;
            end
            ptom_pkg::ST_TRADE:
            begin
                if (rem_after == 16'd0)
                    state_next = ptom_pkg::ST_SUMMARY;
                else if (n_reg + 1'b1 == CNT_MAX)
                    state_next = ptom_pkg::ST_PLACE;
                else
                    state_next = ptom_pkg::ST_SCAN;
            end
            ptom_pkg::ST_PLACE:   state_next = ptom_pkg::ST_SUMMARY;
            ptom_pkg::ST_SUMMARY: state_next = ptom_pkg::ST_IDLE;
            default:              state_next = ptom_pkg::ST_IDLE;
        endcase
    end

    // control and book occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptom_pkg::ST_IDLE;
            next_id_reg    <= 32'd1;
            best_valid_reg <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++)
            begin
                bid_qty_reg[i] <= 16'd0;
                ask_qty_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= (state_reg == ptom_pkg::ST_TRADE)
                          || (state_reg == ptom_pkg::ST_SUMMARY);
            unique case (state_reg)
                ptom_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        next_id_reg    <= next_id_reg + 32'd1;
                        best_valid_reg <= 1'b0;
                        idx_reg        <= '0;
                        n_reg          <= '0;
                    end
                end
                ptom_pkg::ST_SCAN:
                begin
                    if (scan_qty != 16'd0 && scan_better)
                        best_valid_reg <= 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
                ptom_pkg::ST_TRADE:
                begin
                    if (buy_reg)
                        ask_qty_reg[best_idx_reg] <= best_qty_reg - trade_qty;
                    else
                        bid_qty_reg[best_idx_reg] <= best_qty_reg - trade_qty;
                    n_reg          <= n_reg + 1'b1;
                    best_valid_reg <= 1'b0;
                    idx_reg        <= '0;
                end
                ptom_pkg::ST_PLACE:
                begin
                    if (free_found)
                    begin
                        if (buy_reg)
                            bid_qty_reg[free_idx] <= rem_reg;
                        else
                            ask_qty_reg[free_idx] <= rem_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ptom_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    nid_reg <= next_id_reg;
                    buy_reg <= is_buy;
                    lim_reg <= limit_price;
                    rem_reg <= quantity;
                    rej_reg <= (quantity == 16'd0);
                end
            end
            ptom_pkg::ST_SCAN:
            begin
                if (scan_qty != 16'd0 && scan_better)
                begin
                    best_idx_reg   <= idx_reg;
                    best_price_reg <= scan_price;
                    best_qty_reg   <= scan_qty;
                    best_id_reg    <= scan_id;
                end
            end
            ptom_pkg::ST_TRADE:
            begin
                rem_reg        <= rem_after;
                kind_reg       <= ptom_pkg::KIND_TRADE;
                fill_qty_reg   <= trade_qty;
                fill_price_reg <= buy_reg ? best_price_reg : lim_reg;
                buy_id_reg     <= buy_reg ? nid_reg : best_id_reg;
                sell_id_reg    <= buy_reg ? best_id_reg : nid_reg;
                new_id_reg     <= nid_reg;
                rejected_reg   <= 1'b0;
                last_reg       <= 1'b0;
            end
            ptom_pkg::ST_PLACE:
            begin
                rej_reg <= !free_found;
                if (free_found)
                begin
                    if (buy_reg)
                    begin
                        bid_price_reg[free_idx] <= lim_reg;
                        bid_id_reg[free_idx]    <= nid_reg;
                    end
                    else
                    begin
                        ask_price_reg[free_idx] <= lim_reg;
                        ask_id_reg[free_idx]    <= nid_reg;
                    end
                end
            end
            ptom_pkg::ST_SUMMARY:
            begin
                kind_reg       <= ptom_pkg::KIND_SUMMARY;
                fill_qty_reg   <= rem_reg;
                fill_price_reg <= lim_reg;
                buy_id_reg     <= 32'd0;
                sell_id_reg    <= 32'd0;
                new_id_reg     <= nid_reg;
                rejected_reg   <= rej_reg;
                last_reg       <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy          = (state_reg != ptom_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign fill_qty      = fill_qty_reg;
    assign fill_price    = fill_price_reg;
    assign buy_order_id  = buy_id_reg;
    assign sell_order_id = sell_id_reg;
    assign new_order_id  = new_id_reg;
    assign rejected      = rejected_reg;
    assign last          = last_reg;

    // a trade word never closes the run and never carries a reject
    `ASSERT_SAME(a_trade_word, clk, rst_n,
        out_valid && kind == ptom_pkg::KIND_TRADE, !last && !rejected)
    // trades per order stay within the book depth
    `ASSERT_SAME(a_trade_cnt, clk, rst_n, busy, n_reg <= CNT_MAX)
    // an accepted order advances the id counter
    `ASSERT_NEXT(a_id_step, clk, rst_n, start && !busy,
        busy && next_id_reg == $past(next_id_reg) + 32'd1)

endmodule

// ===== tb/price_time_order_matcher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_time_order_matcher_checker
// watches accepted orders, keeps its own order book, and compares each
// trade or summary word against the oldest predicted word
// ----------------------------------------------------------------------------
module price_time_order_matcher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        is_buy,
    input  logic [15:0] limit_price,
    input  logic [15:0] quantity,
    input  logic        out_valid,
    input  logic        kind,
    input  logic [15:0] fill_qty,
    input  logic [15:0] fill_price,
    input  logic [31:0] buy_order_id,
    input  logic [31:0] sell_order_id,
    input  logic [31:0] new_order_id,
    input  logic        rejected,
    input  logic        last,
    output int          fail_count,
    output int          pending_words
);

    localparam int DUE_DEPTH = 1024;

    typedef struct packed {
        logic        kind;
        logic [15:0] qty;
        logic [15:0] price;
        logic [31:0] bid_id;
        logic [31:0] ask_id;
        logic [31:0] nid;
        logic        rej;
        logic        last;
    } fill_word_t;

    // ring of predicted words, oldest at due_rd
    fill_word_t due_words [DUE_DEPTH];
    int due_wr;
    int due_rd;

    // book: index 0 holds bids, index 1 holds asks
    logic [15:0] book_px  [2][ptom_pkg::BOOK_DEPTH];
    logic [15:0] book_qty [2][ptom_pkg::BOOK_DEPTH];
    logic [31:0] book_id  [2][ptom_pkg::BOOK_DEPTH];
    logic [31:0] id_ctr;

    assign pending_words = due_wr - due_rd;

    function automatic fill_word_t make_word(logic k, logic [15:0] q, logic [15:0] p,
                                             logic [31:0] b, logic [31:0] a,
                                             logic [31:0] n, logic r, logic l);
        fill_word_t w;
        w.kind = k; w.qty = q; w.price = p; w.bid_id = b; w.ask_id = a;
        w.nid = n; w.rej = r; w.last = l;
        return w;
    endfunction

    task automatic add_due(input fill_word_t w);
        due_words[due_wr % DUE_DEPTH] = w;
        due_wr = due_wr + 1;
    endtask

    task automatic match_order(input logic buy, input logic [15:0] lim,
                               input logic [15:0] qty_in);
        logic [31:0] nid;
        logic [15:0] rem;
        logic [15:0] tq;
        logic [15:0] px;
        int opp;
        int own;
        int ntr;
        int b;
        int slot;
        bit better;
        nid = id_ctr;
        id_ctr = id_ctr + 32'd1;
        rem = qty_in;
        opp = buy ? 1 : 0;
        own = buy ? 0 : 1;
        ntr = 0;
        if (rem == 16'd0) begin
            add_due(make_word(ptom_pkg::KIND_SUMMARY, 16'd0, lim, 32'd0, 32'd0, nid,
                              1'b1, 1'b1));
            return;
        end
        while (rem != 0 && ntr < ptom_pkg::BOOK_DEPTH) begin
            b = -1;
            for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++) begin
                if (book_qty[opp][i] == 0) continue;
                if (b < 0) begin
                    b = i;
                    continue;
                end
                if (book_px[opp][i] == book_px[opp][b])
                    better = book_id[opp][i] < book_id[opp][b];
                else if (!buy)
                    better = book_px[opp][i] > book_px[opp][b];
                else
                    better = book_px[opp][i] < book_px[opp][b];
                if (better) b = i;
            end
            if (b < 0) break;
            if (buy ? (book_px[opp][b] > lim) : (book_px[opp][b] < lim)) break;
            tq = (rem < book_qty[opp][b]) ? rem : book_qty[opp][b];
            px = buy ? book_px[opp][b] : lim;
            if (buy)
                add_due(make_word(ptom_pkg::KIND_TRADE, tq, px, nid,
                                  book_id[opp][b], nid, 1'b0, 1'b0));
            else
                add_due(make_word(ptom_pkg::KIND_TRADE, tq, px, book_id[opp][b],
                                  nid, nid, 1'b0, 1'b0));
            ntr++;
            rem = rem - tq;
            book_qty[opp][b] = book_qty[opp][b] - tq;
        end
        if (rem == 0) begin
            add_due(make_word(ptom_pkg::KIND_SUMMARY, 16'd0, lim, 32'd0, 32'd0, nid,
                              1'b0, 1'b1));
            return;
        end
        slot = -1;
        for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++)
            if (slot < 0 && book_qty[own][i] == 0) slot = i;
        if (slot < 0) begin
            add_due(make_word(ptom_pkg::KIND_SUMMARY, rem, lim, 32'd0, 32'd0, nid,
                              1'b1, 1'b1));
            return;
        end
        book_px[own][slot] = lim;
        book_qty[own][slot] = rem;
        book_id[own][slot] = nid;
        add_due(make_word(ptom_pkg::KIND_SUMMARY, rem, lim, 32'd0, 32'd0, nid, 1'b0, 1'b1));
    endtask

    task automatic fill_count_reset();
        fail_count <= 0;
        due_wr = 0;
        due_rd = 0;
        id_ctr = 32'd1;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < ptom_pkg::BOOK_DEPTH; i++)
            begin
                book_px[s][i] = '0;
                book_qty[s][i] = '0;
                book_id[s][i] = '0;
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fill_word_t got;
        fill_word_t want;
        if (!rst_n)
        begin
            fill_count_reset();
        end
        else
        begin
            if (out_valid)
            begin
                got = make_word(kind, fill_qty, fill_price, buy_order_id, sell_order_id,
                                new_order_id, rejected, last);
                if (due_wr == due_rd)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected word: %p", got);
                end
                else
                begin
                    want = due_words[due_rd % DUE_DEPTH];
                    due_rd = due_rd + 1;
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            // order accepted this edge; predicted words cannot appear before next cycle
            if (start && !busy)
                match_order(is_buy, limit_price, quantity);
        end
    end

endmodule

// ===== tb/price_time_order_matcher_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_time_order_matcher_top_test
// drives directed limit orders back to back and random ones, mostly with random gaps;
// the checker predicts every trade and summary word
// ----------------------------------------------------------------------------
module price_time_order_matcher_top_test;

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        is_buy;
    logic [15:0] limit_price;
    logic [15:0] quantity;
    logic        out_valid;
    logic        kind;
    logic [15:0] fill_qty;
    logic [15:0] fill_price;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [31:0] new_order_id;
    logic        rejected;
    logic        last;
    int          fail_count;
    int          pending_words;
    int          idle_cycles = 0;

    price_time_order_matcher_top dut (.*);

    price_time_order_matcher_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles with nothing accepted and no output word
    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("price_time_order_matcher_top_test: FAIL");
            $finish;
        end
    end

    // hold one order until accepted; with gaps, start drops in random cycles
    task automatic send_order(input logic buy, input logic [15:0] px,
                              input logic [15:0] qty, input bit gaps);
        bit done;
        done        = 1'b0;
        is_buy      <= buy;
        limit_price <= px;
        quantity    <= qty;
        while (!done)
        begin
            start <= !gaps || ($urandom_range(99) >= 22);
            @(posedge clk);
            done = start && !busy;
        end
    endtask

    initial
    begin
        logic [15:0] px;
        logic [15:0] qty;
        int r;
        rst_n       = 1'b0;
        start       = 1'b0;
        is_buy      = 1'b0;
        limit_price = '0;
        quantity    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero quantity, extremes, full fill, partial, sweep
        send_order(1'b1, 16'd100, 16'd0, 1'b0);
        send_order(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_order(1'b1, 16'h0000, 16'd5, 1'b0);
        send_order(1'b1, 16'hFFFF, 16'd10, 1'b0);
        send_order(1'b0, 16'd500, 16'd7, 1'b0);
        send_order(1'b0, 16'd500, 16'd7, 1'b0);
        send_order(1'b1, 16'd600, 16'd10, 1'b0);
        send_order(1'b0, 16'd0, 16'hFFFF, 1'b0);
        send_order(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        // fill the bid side, then overflow it
        for (int i = 0; i < ptom_pkg::BOOK_DEPTH + 2; i++)
            send_order(1'b1, 16'd10 + 16'(i % 3), 16'd3, 1'b0);
        // one sell sweeps the whole bid side
        send_order(1'b0, 16'd0, 16'hFFFF, 1'b0);
        send_order(1'b0, 16'd0, 16'hFFFF, 1'b0);

        // random: prices clustered so books cross often, with occasional extremes
        for (int n = 0; n < 235; n++)
        begin
            r = $urandom_range(99);
            px = (r < 8) ? 16'($urandom) : 16'(1000 + $urandom_range(40));
            r = $urandom_range(99);
            if (r < 5)
                qty = 16'd0;
            else if (r < 12)
                qty = 16'($urandom);
            else
                qty = 16'($urandom_range(1, 60));
            send_order(1'($urandom), px, qty, !(n >= 100 && n < 160));
        end
        start <= 1'b0;

        while (pending_words != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("price_time_order_matcher_top_test: PASS");
        else
            $display("price_time_order_matcher_top_test: FAIL");
        $finish;
    end

endmodule
